// File: sv/fixed_slot_free_list_allocator_macros.svh
// assertion macros for the fixed slot free list allocator checker
`ifndef FIXED_SLOT_FREE_LIST_ALLOCATOR_MACROS_SVH
`define FIXED_SLOT_FREE_LIST_ALLOCATOR_MACROS_SVH

// same-cycle implication, sampled on clk_i, off during reset
`define FSLA_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, sampled on clk_i, off during reset
`define FSLA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/fsla_pkg.sv
// shared types and constants of the fixed slot free list allocator
package fsla_pkg;

  localparam int unsigned APB_AW         = 4;
  localparam int unsigned STRIDE_W       = 14;
  localparam int unsigned MIN_ALIGN_LOG2 = 2;
  localparam int unsigned MAX_ALIGN_LOG2 = 8;
  localparam int unsigned MIN_STRIDE     = 8;
  localparam logic [19:0] OFFSET_MAX     = 20'hFFFFF;

  localparam logic ACT_ALLOC   = 1'b0;
  localparam logic ACT_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_GRANTED   = 2'd0,
    ST_EXHAUSTED = 2'd1,
    ST_RELEASED  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_ELEM_SIZE  = 2'd0,
    REG_ALIGN_LOG2 = 2'd1,
    REG_SLOT_COUNT = 2'd2
  } reg_idx_e;

  // controller to datapath
  typedef struct packed {
    logic sweep;
    logic pop_done;
    logic exhaust;
    logic rel_op;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic head_valid;
    logic sweep_last;
    logic count_wr;
  } dp_sts_t;

endpackage

// File: sv/fsla_ram.sv
// generic single write port ram with registered read
module fsla_ram #(
  parameter int unsigned WIDTH = 9,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// File: sv/fsla_ctrl.sv
// sequencing state machine of the allocator
module fsla_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic               action_i,
  output logic               busy_o,
  output fsla_pkg::ctrl_cmd_t cmd_o,
  input  fsla_pkg::dp_sts_t   sts_i
);
  import fsla_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_INIT = 3'b010,
    S_POP  = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   accept;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && (state_q == S_IDLE);

  always_comb begin
    cmd_o.sweep    = (state_q == S_INIT);
    cmd_o.pop_done = (state_q == S_POP);
    cmd_o.exhaust  = accept && (action_i == ACT_ALLOC) && !sts_i.head_valid;
    cmd_o.rel_op   = accept && (action_i == ACT_RELEASE);
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept && (action_i == ACT_ALLOC) && sts_i.head_valid) begin
          state_d = S_POP;
        end
      end
      S_INIT: begin
        if (sts_i.sweep_last) begin
          state_d = S_IDLE;
        end
      end
      S_POP: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
    // new slot count restarts the link rebuild
    if (sts_i.count_wr) begin
      state_d = S_INIT;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// File: sv/fsla_dp.sv
// datapath: config registers, head pointer, link ram and result registers
module fsla_dp #(
  parameter int unsigned NUM_SLOTS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic [7:0]                  release_slot_i,
  input  fsla_pkg::ctrl_cmd_t         cmd_i,
  output fsla_pkg::dp_sts_t           sts_o,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fsla_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [7:0]                  slot_index_o,
  output logic [19:0]                 byte_offset_o
);
  import fsla_pkg::*;

  localparam int unsigned IW = $clog2(NUM_SLOTS);
  localparam int unsigned LW = IW + 1;
  localparam int unsigned PW = IW + STRIDE_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(NUM_SLOTS);

  function automatic logic [STRIDE_W-1:0] stride_of(input logic [12:0] es,
                                                   input logic [3:0]  al);
    logic [3:0]          a;
    logic [8:0]          alb;
    logic [STRIDE_W-1:0] msk;
    logic [STRIDE_W-1:0] s;
    a = al;
    if (a > 4'(MAX_ALIGN_LOG2)) a = 4'(MAX_ALIGN_LOG2);
    if (a < 4'(MIN_ALIGN_LOG2)) a = 4'(MIN_ALIGN_LOG2);
    alb = 9'd1 << a;
    msk = STRIDE_W'(alb) - STRIDE_W'(1);
    s   = (STRIDE_W'(es) + msk) & ~msk;
    if (s < STRIDE_W'(MIN_STRIDE)) s = STRIDE_W'(MIN_STRIDE);
    return s;
  endfunction

  // configuration
  logic [12:0]         elem_size_q, elem_size_d;
  logic [3:0]          align_q, align_d;
  logic [8:0]          count_q, count_d;
  logic [STRIDE_W-1:0] stride_q, stride_d;
  logic                cfg_wr;
  logic [1:0]          cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];

  always_comb begin
    elem_size_d = elem_size_q;
    align_d     = align_q;
    count_d     = count_q;
    if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ELEM_SIZE:  elem_size_d = pwdata[12:0];
        REG_ALIGN_LOG2: align_d     = pwdata[3:0];
        REG_SLOT_COUNT: count_d     = pwdata[8:0];
        default: ;
      endcase
    end
    stride_d = stride_of(elem_size_d, align_d);
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_idx)
      REG_ELEM_SIZE:  prdata = 32'(elem_size_q);
      REG_ALIGN_LOG2: prdata = 32'(align_q);
      REG_SLOT_COUNT: prdata = 32'(count_q);
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      elem_size_q <= 13'd8;
      align_q     <= 4'd2;
      count_q     <= 9'd256;
      stride_q    <= STRIDE_W'(MIN_STRIDE);
    end else begin
      elem_size_q <= elem_size_d;
      align_q     <= align_d;
      count_q     <= count_d;
      stride_q    <= stride_d;
    end
  end

  // free list
  logic [IW-1:0] head_q, head_d;
  logic          head_valid_q, head_valid_d;
  logic [IW-1:0] sweep_q, sweep_d;
  logic          sweep_last;
  logic          count_wr;
  logic          rel_ok;
  logic          ram_we;
  logic [IW-1:0] ram_waddr;
  logic [LW-1:0] ram_wdata;
  logic [LW-1:0] ram_rdata;
  logic          next_null;

  assign count_wr   = cfg_wr && (cfg_idx == REG_SLOT_COUNT);
  assign sweep_last = (sweep_q == IW'(NUM_SLOTS - 1));
  assign rel_ok     = ({24'd0, release_slot_i} < 32'(NUM_SLOTS));
  assign next_null  = (ram_rdata >= NULL_LINK);

  assign sts_o.head_valid = head_valid_q;
  assign sts_o.sweep_last = sweep_last;
  assign sts_o.count_wr   = count_wr;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sweep_q;
    ram_wdata = NULL_LINK;
    if (cmd_i.sweep) begin
      ram_we = 1'b1;
      // counts above the depth end on the null link at the top entry anyway
      if (32'(sweep_q) + 32'd1 < 32'(count_q)) begin
        ram_wdata = LW'(sweep_q) + LW'(1);
      end
    end else if (cmd_i.rel_op && rel_ok) begin
      ram_we    = 1'b1;
      ram_waddr = IW'(release_slot_i);
      ram_wdata = head_valid_q ? {1'b0, head_q} : NULL_LINK;
    end
  end

  always_comb begin
    head_d       = head_q;
    head_valid_d = head_valid_q;
    sweep_d      = sweep_q;
    if (cmd_i.sweep) begin
      sweep_d = sweep_last ? '0 : sweep_q + IW'(1);
    end
    if (cmd_i.pop_done) begin
      if (next_null) begin
        head_d       = '0;
        head_valid_d = 1'b0;
      end else begin
        head_d = ram_rdata[IW-1:0];
      end
    end
    if (cmd_i.rel_op && rel_ok) begin
      head_d       = IW'(release_slot_i);
      head_valid_d = 1'b1;
    end
    if (count_wr) begin
      head_d       = '0;
      head_valid_d = (pwdata[8:0] != 9'd0);
      sweep_d      = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q       <= '0;
      head_valid_q <= 1'b1;
      sweep_q      <= '0;
    end else begin
      head_q       <= head_d;
      head_valid_q <= head_valid_d;
      sweep_q      <= sweep_d;
    end
  end

  fsla_ram #(
    .WIDTH (LW),
    .DEPTH (NUM_SLOTS)
  ) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (head_q),
    .rdata_o (ram_rdata)
  );

  // result
  logic [PW-1:0] prod;
  logic [19:0]   offset_sat;
  logic          done_q;
  logic [1:0]    status_q, status_d;
  logic [7:0]    index_q, index_d;
  logic [19:0]   offset_q, offset_d;

  assign prod       = PW'(head_q) * PW'(stride_q);
  assign offset_sat = (32'(prod) > 32'(OFFSET_MAX)) ? OFFSET_MAX : 20'(prod);

  always_comb begin
    status_d = ST_RELEASED;
    index_d  = '0;
    offset_d = '0;
    if (cmd_i.pop_done) begin
      status_d = ST_GRANTED;
      index_d  = 8'(head_q);
      offset_d = offset_sat;
    end else if (cmd_i.exhaust) begin
      status_d = ST_EXHAUSTED;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= cmd_i.pop_done || cmd_i.exhaust || cmd_i.rel_op;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    index_q  <= index_d;
    offset_q <= offset_d;
  end

  assign done_o        = done_q;
  assign status_o      = status_q;
  assign slot_index_o  = index_q;
  assign byte_offset_o = offset_q;

endmodule

// File: sv/fixed_slot_free_list_allocator.sv
// top level of the fixed slot free list allocator
//
// channel   direction  handshake                 payload
// -------   ---------  ------------------------  -------------------------------------
// request   in         start high, busy low      action_i, release_slot_i
// result    out        done_o, one-cycle strobe  status_o, slot_index_o, byte_offset_o
// config    in/out     apb, psel+penable+pwrite  paddr, pwdata, prdata (pready tied high)
//
// allocate with a free slot: the head's link is read from the link ram
//   in the cycle after the transaction, the result strobes in the cycle after that
// allocate on an empty list and release: result strobes in the next cycle
// reset and every slot_count write rebuild the link ram, one entry a cycle,
//   with busy high; config writes are still taken then
// the result is never held off, done_o is high for exactly one cycle per transaction
module fixed_slot_free_list_allocator #(
  // number of entries of the link ram; slots at or above it are never handed out
  parameter int unsigned NUM_SLOTS = 256
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request
  input  logic                        start,
  output logic                        busy,
  input  logic                        action_i,
  input  logic [7:0]                  release_slot_i,
  // result
  output logic                        done_o,
  output logic [1:0]                  status_o,
  output logic [7:0]                  slot_index_o,
  output logic [19:0]                 byte_offset_o,
  // configuration
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [fsla_pkg::APB_AW-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);
  import fsla_pkg::*;

  ctrl_cmd_t cmd;
  dp_sts_t   sts;

  // zero wait state register port
  assign pready = 1'b1;

  // state machine: rebuild sweep, idle, and the wait for the link read of a pop
  fsla_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .action_i (action_i),
    .busy_o   (busy),
    .cmd_o    (cmd),
    .sts_i    (sts)
  );

  // config registers, stride, head pointer, link ram, offset multiplier, results
  fsla_dp #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .release_slot_i (release_slot_i),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .done_o         (done_o),
    .status_o       (status_o),
    .slot_index_o   (slot_index_o),
    .byte_offset_o  (byte_offset_o)
  );

endmodule

// File: sv/fsla_checker.sv
// port-level checker of the allocator and its bind
`include "fixed_slot_free_list_allocator_macros.svh"

module fsla_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic        action_i,
  input logic        done_o,
  input logic [1:0]  status_o,
  input logic [7:0]  slot_index_o,
  input logic [19:0] byte_offset_o
);
  import fsla_pkg::*;

  logic acc_rel;
  logic acc_alloc;
  logic rel_seen;
  logic alloc_step;
  logic grant_seen;
  logic other_seen;
  logic slot_zero;

  assign acc_rel    = start && !busy && (action_i == ACT_RELEASE);
  assign acc_alloc  = start && !busy && (action_i == ACT_ALLOC);
  assign rel_seen   = done_o && (status_o == ST_RELEASED);
  assign alloc_step = (done_o && (status_o == ST_EXHAUSTED)) || (busy && !done_o);
  assign grant_seen = done_o && (status_o == ST_GRANTED);
  assign other_seen = done_o && (status_o != ST_GRANTED);
  assign slot_zero  = (slot_index_o == 8'd0) && (byte_offset_o == 20'd0);

  // a release always answers in the next cycle
  `FSLA_ASSERT_NEXT(a_rel_answer, acc_rel, rel_seen, "release not answered")

  // an allocate either answers exhausted at once or waits on the link read
  `FSLA_ASSERT_NEXT(a_alloc_answer, acc_alloc, alloc_step, "allocate answer out of order")

  // a grant follows a busy cycle spent on the link read
  `FSLA_ASSERT_NOW(a_grant_after_read, grant_seen, $past(busy), "grant without link read")

  // only a grant carries a slot
  `FSLA_ASSERT_NOW(a_no_slot_data, other_seen, slot_zero, "slot data on non-grant")

endmodule

bind fixed_slot_free_list_allocator fsla_checker u_fsla_checker (.*);

// File: test/tb_top.sv
// self-checking testbench for the fixed slot free list allocator
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import fsla_pkg::*;

  // link ram depth of the instance; a link at or above it means end of list
  localparam int unsigned POOL_SLOTS    = 256;
  localparam int unsigned NULL_LINK     = POOL_SLOTS;
  // cycles left to run once nothing is owed any more
  localparam int unsigned SETTLE_CYCLES = 8;
  localparam int unsigned RANDOM_PHASES = 12;
  localparam int unsigned PHASE_OPS     = 71;

  // one request transaction as queued for the driver, with its lead-in gap
  typedef struct {
    logic        act;
    logic [7:0]  slot;
    int unsigned gap;
  } pool_op_t;

  // one result transaction as the pool should answer it
  typedef struct {
    status_e     status;
    logic [7:0]  slot;
    logic [19:0] offset;
  } pool_reply_t;

  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                start          = 1'b0;
  logic                busy;
  logic                action_i       = ACT_ALLOC;
  logic [7:0]          release_slot_i = '0;
  logic                done_o;
  logic [1:0]          status_o;
  logic [7:0]          slot_index_o;
  logic [19:0]         byte_offset_o;
  logic                psel           = 1'b0;
  logic                penable        = 1'b0;
  logic                pwrite         = 1'b0;
  logic [APB_AW-1:0]   paddr          = '0;
  logic [31:0]         pwdata         = '0;
  logic [31:0]         prdata;
  logic                pready;

  // requests still to be driven, and answers still to arrive
  pool_op_t            op_backlog[$];
  pool_reply_t         owed_replies[$];
  int unsigned         err_count   = 0;
  int unsigned         wait_cycles = 0;
  pool_op_t            cur_op;
  bit                  quiet       = 1'b0;

  // shadow of the pool: register copies, the link table and the list head
  logic [12:0]         cfg_elem;
  logic [3:0]          cfg_align;
  logic [8:0]          cfg_count;
  logic [8:0]          link_ram[POOL_SLOTS];
  logic [8:0]          free_head;
  logic                free_valid;

  fixed_slot_free_list_allocator #(
    .NUM_SLOTS(POOL_SLOTS)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .action_i      (action_i),
    .release_slot_i(release_slot_i),
    .done_o        (done_o),
    .status_o      (status_o),
    .slot_index_o  (slot_index_o),
    .byte_offset_o (byte_offset_o),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  task automatic flag_mismatch(string msg);
    $display("mismatch at %0t: %s", $time, msg);
    err_count++;
  endtask

  // chain the first count slots in order, slot 0 at the head; counts above
  // the ram depth are clipped, a zero count leaves the list empty
  function automatic void rebuild_free_list();
    int unsigned n;
    n = (cfg_count > POOL_SLOTS) ? POOL_SLOTS : cfg_count;
    for (int unsigned i = 0; i < POOL_SLOTS; i++) begin
      link_ram[i] = (i + 1 < n) ? 9'(i + 1) : 9'(NULL_LINK);
    end
    free_head  = '0;
    free_valid = (n > 0);
  endfunction

  // stride is the element size rounded up to the alignment, which is at
  // least 4 and capped at 256; the stride itself is never below 8 and the
  // product saturates at the top of the 20-bit offset range
  function automatic logic [19:0] slot_offset(logic [7:0] idx);
    int unsigned a;
    int unsigned al;
    int unsigned stride;
    int unsigned prod;
    a = (cfg_align > MAX_ALIGN_LOG2) ? MAX_ALIGN_LOG2 : cfg_align;
    if (a < MIN_ALIGN_LOG2) a = MIN_ALIGN_LOG2;
    al = 1 << a;
    stride = (cfg_elem + al - 1) & ~(al - 1);
    if (stride < MIN_STRIDE) stride = MIN_STRIDE;
    prod = idx * stride;
    return (prod > OFFSET_MAX) ? OFFSET_MAX : prod[19:0];
  endfunction

  // pop the head on allocate, push the slot on release; releases are never
  // checked, so a double release simply forms a cycle in the list
  function automatic void predict_pool_op(pool_op_t op);
    pool_reply_t r;
    logic [8:0]  idx;
    r.status = ST_EXHAUSTED;
    r.slot   = '0;
    r.offset = '0;
    if (op.act == ACT_ALLOC) begin
      if (free_valid && free_head < POOL_SLOTS) begin
        idx      = free_head;
        r.status = ST_GRANTED;
        r.slot   = idx[7:0];
        r.offset = slot_offset(idx[7:0]);
        if (link_ram[idx] >= NULL_LINK) begin
          free_valid = 1'b0;
          free_head  = '0;
        end else begin
          free_head = link_ram[idx];
        end
      end
    end else begin
      link_ram[op.slot] = free_valid ? free_head : 9'(NULL_LINK);
      free_head         = {1'b0, op.slot};
      free_valid        = 1'b1;
      r.status          = ST_RELEASED;
    end
    owed_replies.push_back(r);
  endfunction

  // driver: a request is taken at an edge with start high and busy low;
  // start stays high across back-to-back requests, so it gets a single
  // assignment per edge
  always @(posedge clk_i) begin
    logic taken;
    logic next_start;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      taken      = start && !busy;
      next_start = start && !taken;
      if (taken) predict_pool_op(cur_op);
      if (!next_start && op_backlog.size() != 0) begin
        if (wait_cycles < op_backlog[0].gap) begin
          wait_cycles++;
        end else begin
          cur_op         = op_backlog.pop_front();
          wait_cycles    = 0;
          next_start     = 1'b1;
          action_i       <= cur_op.act;
          release_slot_i <= cur_op.slot;
        end
      end
      start <= next_start;
    end
  end

  // monitor: every done strobe is one result transaction, checked field by
  // field against the oldest answer still owed
  always @(posedge clk_i) begin
    pool_reply_t want;
    if (rst_ni && done_o) begin
      if (owed_replies.size() == 0) begin
        flag_mismatch($sformatf("result with none owed, status %0d slot %0d offset %0d",
                                status_o, slot_index_o, byte_offset_o));
      end else begin
        want = owed_replies.pop_front();
        if (status_o !== want.status)
          flag_mismatch($sformatf("status %0d, expected %0d", status_o, want.status));
        if (slot_index_o !== want.slot)
          flag_mismatch($sformatf("slot_index %0d, expected %0d", slot_index_o, want.slot));
        if (byte_offset_o !== want.offset)
          flag_mismatch($sformatf("byte_offset %0d, expected %0d",
                                  byte_offset_o, want.offset));
      end
    end
  end

  // long runs of back-to-back requests alternate with random gaps
  function automatic int unsigned draw_gap();
    if ($urandom_range(0, 9) == 0) quiet = !quiet;
    return quiet ? 0 : $urandom_range(0, 14);
  endfunction

  function automatic void queue_op(logic act, logic [7:0] slot);
    pool_op_t op;
    op.act  = act;
    op.slot = slot;
    op.gap  = draw_gap();
    op_backlog.push_back(op);
  endfunction

  // wait until every queued request went out and every answer came back
  task automatic drain();
    while (op_backlog.size() != 0 || start || owed_replies.size() != 0)
      @(posedge clk_i);
  endtask

  // setup then access cycle; the register takes the value at the edge
  // that ends the access cycle, and the shadow follows at that edge
  task automatic apb_write(reg_idx_e idx, logic [31:0] value);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_ELEM_SIZE:  cfg_elem  = value[12:0];
      REG_ALIGN_LOG2: cfg_align = value[3:0];
      REG_SLOT_COUNT: begin
        cfg_count = value[8:0];
        rebuild_free_list();
      end
      default: ;
    endcase
  endtask

  // a slot count write rebuilds the list; leaving it out keeps the list
  // as the previous phase left it while the stride changes
  task automatic set_pool(int unsigned elem, int unsigned align, int unsigned count,
                          bit rebuild);
    apb_write(REG_ELEM_SIZE, elem);
    apb_write(REG_ALIGN_LOG2, align);
    if (rebuild) apb_write(REG_SLOT_COUNT, count);
  endtask

  initial begin
    int unsigned elem;
    int unsigned align;
    int unsigned count;
    int unsigned lim;
    logic [7:0]  slot;

    cfg_elem  = 13'd8;
    cfg_align = 4'd2;
    cfg_count = 9'd256;
    rebuild_free_list();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: in-order pops, a double release that makes slot 1
    // link to itself, and a release of a slot that is still free
    queue_op(ACT_ALLOC, 8'd0);
    queue_op(ACT_ALLOC, 8'd0);
    queue_op(ACT_ALLOC, 8'd0);
    queue_op(ACT_RELEASE, 8'd1);
    queue_op(ACT_RELEASE, 8'd1);
    queue_op(ACT_ALLOC, 8'd0);
    queue_op(ACT_ALLOC, 8'd0);
    queue_op(ACT_RELEASE, 8'd255);
    queue_op(ACT_ALLOC, 8'd255);
    drain();

    // zero element size, alignment above the cap, empty list; a release
    // above the slot count is still pushed
    set_pool(0, 15, 0, 1'b1);
    queue_op(ACT_ALLOC, 8'd0);
    queue_op(ACT_RELEASE, 8'd200);
    queue_op(ACT_ALLOC, 8'd0);
    queue_op(ACT_ALLOC, 8'd0);
    drain();

    // largest stride, slot count above the ram depth, offsets that saturate
    set_pool(8191, 8, 511, 1'b1);
    queue_op(ACT_ALLOC, 8'd0);
    queue_op(ACT_ALLOC, 8'd0);
    queue_op(ACT_RELEASE, 8'd255);
    queue_op(ACT_ALLOC, 8'd0);
    queue_op(ACT_RELEASE, 8'd128);
    drain();

    // one-slot pool with element size 1 and the smallest alignment
    set_pool(1, 0, 1, 1'b1);
    queue_op(ACT_ALLOC, 8'd0);
    queue_op(ACT_ALLOC, 8'd0);
    queue_op(ACT_RELEASE, 8'd0);
    queue_op(ACT_RELEASE, 8'd0);
    queue_op(ACT_ALLOC, 8'd0);
    queue_op(ACT_ALLOC, 8'd0);
    drain();

    // random phases: mostly small pools so the list empties and refills,
    // releases mostly of slots inside the pool, some anywhere in the ram
    for (int unsigned ph = 0; ph < RANDOM_PHASES; ph++) begin
      case ($urandom_range(0, 3))
        0: begin
          case ($urandom_range(0, 3))
            0:       elem = 0;
            1:       elem = 1;
            2:       elem = 4096;
            default: elem = 8191;
          endcase
        end
        default: elem = $urandom_range(1, 4096);
      endcase
      align = $urandom_range(0, 15);
      case ($urandom_range(0, 9))
        0: begin
          case ($urandom_range(0, 3))
            0:       count = 0;
            1:       count = 1;
            2:       count = 256;
            default: count = 511;
          endcase
        end
        1, 2:    count = $urandom_range(1, 256);
        default: count = $urandom_range(2, 24);
      endcase
      set_pool(elem, align, count, (ph == 0) || ($urandom_range(0, 3) != 0));

      lim = (cfg_count == 0) ? 1 : ((cfg_count > POOL_SLOTS) ? POOL_SLOTS : cfg_count);
      for (int unsigned k = 0; k < PHASE_OPS; k++) begin
        slot = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, lim - 1));
        queue_op(($urandom_range(0, 99) < 55) ? ACT_ALLOC : ACT_RELEASE, slot);
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (owed_replies.size() != 0)
      flag_mismatch($sformatf("%0d results never arrived", owed_replies.size()));
    if (err_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // hang guard, far above the slowest correct run including every rebuild
  initial begin
    #3_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: filelist.f
+incdir+sv
sv/fsla_pkg.sv
sv/fsla_ram.sv
sv/fsla_ctrl.sv
sv/fsla_dp.sv
sv/fixed_slot_free_list_allocator.sv
sv/fsla_checker.sv
test/tb_top.sv
